>>> hdl/ssp_pkg.sv
// Shared types and constants for the seeded shuffle permutation core.
`default_nettype none

package ssp_pkg;

	// Count width: deck sizes up to 64 plus the value 64 itself.
	localparam int CW = 7;
	// Width of one stored entry and of the emitted slot and index fields.
	localparam int DW = 6;
	localparam int RESULT_LIMIT = 64;
	localparam logic [CW-1:0] DECK_SIZE_RESET = 7'd9;

	// splitmix64 constants.
	localparam logic [63:0] C_GOLDEN = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [63:0] C_MIX1   = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [63:0] C_MIX2   = 64'h94D0_49BB_1331_11EB;
	localparam int SH_ADD  = 30;
	localparam int SH_MIX1 = 27;
	localparam int SH_MIX2 = 31;

	// Remainder unit: bits consumed per cycle and steps per 64-bit value.
	localparam int MOD_DIGIT = 4;
	localparam int MOD_STEPS = 64 / MOD_DIGIT;
	localparam int DIG_W     = $clog2(MOD_STEPS);

	// Partial product phases of the 64x64 low-half multiply.
	localparam logic [1:0] MP_LL = 2'd0;
	localparam logic [1:0] MP_LH = 2'd1;
	localparam logic [1:0] MP_HL = 2'd2;

	// Datapath operations.
	localparam logic [3:0] OP_NOP  = 4'd0;
	localparam logic [3:0] OP_SEED = 4'd1;
	localparam logic [3:0] OP_INIT = 4'd2;
	localparam logic [3:0] OP_ADD  = 4'd3;
	localparam logic [3:0] OP_MUL  = 4'd4;
	localparam logic [3:0] OP_MIX1 = 4'd5;
	localparam logic [3:0] OP_MIX2 = 4'd6;
	localparam logic [3:0] OP_MOD  = 4'd7;
	localparam logic [3:0] OP_SWRD = 4'd8;
	localparam logic [3:0] OP_SWWI = 4'd9;
	localparam logic [3:0] OP_SWWJ = 4'd10;
	localparam logic [3:0] OP_EMIT = 4'd11;

	typedef struct packed {
		logic [3:0]    op;
		logic          mul_sel;
		logic [1:0]    mul_ph;
		logic [CW-1:0] idx;
		logic [CW-1:0] n;
		logic          last;
	} cmd_t;

endpackage

`default_nettype wire

>>> hdl/seeded_shuffle_permutation_core.sv
// Top level of the seeded shuffle permutation core: sequencer plus datapath.
//
// Usage: write deck_size on the cfg channel (cfg_ready is always high) while
// the core is idle. Pulse start with a 64-bit seed while busy is low; the core
// seeds a splitmix64 generator, loads the identity order of n = min(deck_size,
// capacity) entries, runs one Fisher-Yates pass and then streams n results.
// Each result beat shows position, entry_index and last for one cycle, marked
// by result_strobe; last flags the final slot. The receiver takes every beat.
// A request runs the start, the load of n entries, n-1 Fisher-Yates steps and
// the emission of n results, the first result in the cycle after emission
// begins. Each Fisher-Yates step is one add, two 64-bit multiplies of three
// 32x32 partial products each on the single shared multiplier, two mix steps,
// 16 remainder steps at four bits each, then a read and two writes on the one
// write port of the entry memory. A deck size of zero only loads the seed and
// produces no beat.
// Reset: arst_n clears the sequencer to idle and deck_size to 9; the entry
// memory is left undefined and is always written before it is read.
`default_nettype none

module seeded_shuffle_permutation_core #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [63:0]             seed,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [ssp_pkg::CW-1:0]  deck_size,
	output logic                    result_strobe,
	output logic [ssp_pkg::DW-1:0]  position,
	output logic [ssp_pkg::DW-1:0]  entry_index,
	output logic                    last
);
	import ssp_pkg::*;

	cmd_t cmd;

	// Config writes are always taken; they land only while idle by contract.
	assign cfg_ready = 1'b1;

	ssp_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.deck_size (deck_size),
		.cmd       (cmd)
	);

	ssp_dp #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.seed          (seed),
		.result_strobe (result_strobe),
		.position      (position),
		.entry_index   (entry_index),
		.last          (last)
	);

endmodule

`default_nettype wire

>>> hdl/ssp_ctrl.sv
// Sequencer for the shuffle core: holds the deck size register and issues datapath commands.
`default_nettype none

module ssp_ctrl #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     cfg_valid,
	input  logic [ssp_pkg::CW-1:0]   deck_size,
	output ssp_pkg::cmd_t            cmd
);
	import ssp_pkg::*;

	localparam int CAP_I = (MAX_ENTRIES < RESULT_LIMIT) ? MAX_ENTRIES : RESULT_LIMIT;
	localparam logic [CW-1:0] CAP = CW'(CAP_I);
	localparam logic [CW-1:0] ONE = CW'(1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_INIT = 4'd1;
	localparam logic [3:0] S_ADD  = 4'd2;
	localparam logic [3:0] S_MUL1 = 4'd3;
	localparam logic [3:0] S_MIX1 = 4'd4;
	localparam logic [3:0] S_MUL2 = 4'd5;
	localparam logic [3:0] S_MIX2 = 4'd6;
	localparam logic [3:0] S_MOD  = 4'd7;
	localparam logic [3:0] S_SWRD = 4'd8;
	localparam logic [3:0] S_SWWI = 4'd9;
	localparam logic [3:0] S_SWWJ = 4'd10;
	localparam logic [3:0] S_EMIT = 4'd11;

	logic [3:0]       state_q;
	logic [CW-1:0]    deck_q;
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    i_q;
	logic [1:0]       ph_q;
	logic [DIG_W-1:0] dig_q;
	logic [CW-1:0]    n_in;
	logic [CW-1:0]    i_nx;
	logic [CW-1:0]    i_nx2;

	assign n_in  = (deck_q > CAP) ? CAP : deck_q;
	assign i_nx  = i_q + ONE;
	assign i_nx2 = i_nx + ONE;
	assign busy  = (state_q != S_IDLE);

	always_comb begin
		cmd.op      = OP_NOP;
		cmd.mul_sel = 1'b0;
		cmd.mul_ph  = ph_q;
		cmd.idx     = i_q;
		cmd.n       = n_q;
		cmd.last    = (i_nx == n_q);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op = OP_SEED;
				end
			end
			S_INIT: cmd.op = OP_INIT;
			S_ADD:  cmd.op = OP_ADD;
			S_MUL1: cmd.op = OP_MUL;
			S_MIX1: cmd.op = OP_MIX1;
			S_MUL2: begin
				cmd.op      = OP_MUL;
				cmd.mul_sel = 1'b1;
			end
			S_MIX2: cmd.op = OP_MIX2;
			S_MOD:  cmd.op = OP_MOD;
			S_SWRD: cmd.op = OP_SWRD;
			S_SWWI: cmd.op = OP_SWWI;
			S_SWWJ: cmd.op = OP_SWWJ;
			S_EMIT: cmd.op = OP_EMIT;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			deck_q  <= DECK_SIZE_RESET;
			n_q     <= '0;
			i_q     <= '0;
			ph_q    <= MP_LL;
			dig_q   <= '0;
		end else begin
			if (cfg_valid) begin
				deck_q <= deck_size;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						n_q <= n_in;
						i_q <= '0;
						if (n_in != '0) begin
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					if (i_nx == n_q) begin
						i_q     <= '0;
						state_q <= (n_q == ONE) ? S_EMIT : S_ADD;
					end else begin
						i_q <= i_nx;
					end
				end
				S_ADD: begin
					ph_q    <= MP_LL;
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					if (ph_q == MP_HL) begin
						ph_q    <= MP_LL;
						state_q <= S_MIX1;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				S_MIX1: state_q <= S_MUL2;
				S_MUL2: begin
					if (ph_q == MP_HL) begin
						ph_q    <= MP_LL;
						state_q <= S_MIX2;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				S_MIX2: begin
					dig_q   <= '0;
					state_q <= S_MOD;
				end
				S_MOD: begin
					dig_q <= dig_q + DIG_W'(1);
					if (dig_q == DIG_W'(MOD_STEPS - 1)) begin
						state_q <= S_SWRD;
					end
				end
				S_SWRD: state_q <= S_SWWI;
				S_SWWI: state_q <= S_SWWJ;
				S_SWWJ: begin
					if (i_nx2 < n_q) begin
						i_q     <= i_nx;
						state_q <= S_ADD;
					end else begin
						i_q     <= '0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					i_q <= i_nx;
					if (i_nx == n_q) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hdl/ssp_dp.sv
// Datapath of the shuffle core: splitmix64 generator, shared multiplier, remainder unit, entry memory.
`default_nettype none

module ssp_dp #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ssp_pkg::cmd_t           cmd,
	input  logic [63:0]             seed,
	output logic                    result_strobe,
	output logic [ssp_pkg::DW-1:0]  position,
	output logic [ssp_pkg::DW-1:0]  entry_index,
	output logic                    last
);
	import ssp_pkg::*;

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [63:0]   rng_q;
	logic [63:0]   z_q;
	logic [63:0]   acc_q;
	logic [DW-1:0] rem_q;
	logic [AW-1:0] j_q;
	logic [DW-1:0] perm_q [MAX_ENTRIES];
	logic [DW-1:0] rd_a_q;
	logic [DW-1:0] rd_b_q;
	logic [DW-1:0] position_s1;
	logic          last_s1;
	logic          valid_s1;

	logic [63:0]   rng_sum;
	logic [63:0]   mul_b;
	logic [31:0]   mx;
	logic [31:0]   my;
	logic [63:0]   prod;
	logic [CW-1:0] span;
	logic [DW-1:0] rem_nx;
	logic [CW-1:0] j_nx;
	logic [AW-1:0] i_addr;
	logic          we;
	logic [AW-1:0] wa;
	logic [DW-1:0] wd;

	assign rng_sum = rng_q + C_GOLDEN;
	assign mul_b   = cmd.mul_sel ? C_MIX2 : C_MIX1;
	assign mx      = (cmd.mul_ph == MP_HL) ? z_q[63:32] : z_q[31:0];
	assign my      = (cmd.mul_ph == MP_LH) ? mul_b[63:32] : mul_b[31:0];
	assign prod    = mx * my;
	assign span    = cmd.n - cmd.idx;
	assign j_nx    = cmd.idx + CW'(rem_q);
	assign i_addr  = AW'(cmd.idx);

	// Restoring remainder, MOD_DIGIT bits of the draw per cycle, top bits first.
	always_comb begin : rem_step
		logic [DW:0]   t;
		logic [DW-1:0] r;
		r = rem_q;
		t = '0;
		for (int k = 0; k < MOD_DIGIT; k++) begin
			t = {r, z_q[63-k]};
			if (t >= span) begin
				t = t - span;
			end
			r = t[DW-1:0];
		end
		rem_nx = r;
	end

	always_comb begin
		we = 1'b0;
		wa = i_addr;
		wd = cmd.idx[DW-1:0];
		unique case (cmd.op)
			OP_INIT: we = 1'b1;
			OP_SWWI: begin
				we = 1'b1;
				wd = rd_b_q;
			end
			OP_SWWJ: begin
				we = 1'b1;
				wa = j_q;
				wd = rd_a_q;
			end
			default: we = 1'b0;
		endcase
	end

	// Entry memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (we) begin
			perm_q[wa] <= wd;
		end
		if (cmd.op == OP_SWRD || cmd.op == OP_EMIT) begin
			rd_a_q <= perm_q[i_addr];
		end
		if (cmd.op == OP_SWRD) begin
			rd_b_q <= perm_q[AW'(j_nx)];
			j_q    <= AW'(j_nx);
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_SEED: rng_q <= seed;
			OP_ADD: begin
				rng_q <= rng_sum;
				z_q   <= rng_sum ^ (rng_sum >> SH_ADD);
			end
			OP_MUL: begin
				case (cmd.mul_ph)
					MP_LL:   acc_q <= prod;
					default: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
				endcase
			end
			OP_MIX1: z_q <= acc_q ^ (acc_q >> SH_MIX1);
			OP_MIX2: begin
				z_q   <= acc_q ^ (acc_q >> SH_MIX2);
				rem_q <= '0;
			end
			OP_MOD: begin
				z_q   <= z_q << MOD_DIGIT;
				rem_q <= rem_nx;
			end
			OP_EMIT: begin
				position_s1 <= cmd.idx[DW-1:0];
				last_s1     <= cmd.last;
			end
			default: rng_q <= rng_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (cmd.op == OP_EMIT);
		end
	end

	assign result_strobe = valid_s1;
	assign position      = position_s1;
	assign entry_index   = rd_a_q;
	assign last          = last_s1;

endmodule

`default_nettype wire
